@@ rtl/gbnm_pkg.sv @@
// Package: shared types and constants for greedy box NMS with merge.
package gbnm_pkg;

   localparam logic [15:0] IOU_THR_RESET   = 16'd29491;
   localparam logic [15:0] MERGE_IOU_RESET = 16'd58982;
   localparam logic [15:0] MERGE_TOL_RESET = 16'd9830;

   localparam logic [1:0] REG_IOU_THR   = 2'd0;
   localparam logic [1:0] REG_MERGE_IOU = 2'd1;
   localparam logic [1:0] REG_MERGE_TOL = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_WRITE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [15:0] iou_thr;
      logic [15:0] merge_iou;
      logic [15:0] merge_tol;
   } cfg_type;

endpackage

@@ rtl/gbnm_cfg.sv @@
// Configuration register file for the NMS thresholds.
module gbnm_cfg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data,
   output gbnm_pkg::cfg_type    cfg
);
   import gbnm_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.iou_thr   <= IOU_THR_RESET;
         cfg_ff.merge_iou <= MERGE_IOU_RESET;
         cfg_ff.merge_tol <= MERGE_TOL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_IOU_THR:   cfg_ff.iou_thr   <= csr_data;
            REG_MERGE_IOU: cfg_ff.merge_iou <= csr_data;
            REG_MERGE_TOL: cfg_ff.merge_tol <= csr_data;
            default: ;
         endcase
      end
   end
endmodule

@@ rtl/greedy_box_nms_with_merge.sv @@
// Top level: greedy box NMS with merge marking.
//
// Boxes arrive on the req_ stream in descending score order, one beat per
// box; req_tuser carries first_of_frame, which empties the kept table.
// Each box is compared with every kept box, one kept slot per cycle through
// one shared intersection/union unit (one intersection product per cycle,
// then the two 16x26 threshold products in the following cycle). A box
// passes ST_READ, ST_WRITE and ST_OUT before rsp_tvalid rises; the block
// is not ready on req_ from the accepting edge until it is back in ST_IDLE
// with the response taken, so no new box enters before the last is through.
// One rsp_ beat per box gives keep, slot, merge_mask and overflow. The
// result is held in an output register until rsp_tready; while the
// receiver stalls no new box is accepted.
// Thresholds are written on csr_ (0 iou_threshold, 1 merge IoU threshold,
// 2 merge_score_tolerance), by the user only while idle (not enforced).
// Reset (synchronous, active high) restores the register defaults and
// empties the kept table; no clearing pass is needed.
module greedy_box_nms_with_merge #(
   parameter int MAX_KEPT   = 32,
   parameter int COORD_BITS = 13
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // box_left, box_top, box_width, box_height, score, class_id, color_id, zero fill
   input  logic [((2*COORD_BITS+53)/8)*8-1:0] req_tdata,
   // first_of_frame
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // keep, slot[5], merge_mask[32], overflow, zero fill
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import gbnm_pkg::*;

   localparam int CB  = COORD_BITS;
   // right and bottom edges need room for a corner plus a 12-bit size
   localparam int EB  = ((CB > 13) ? CB : 13) + 1;
   localparam int IW  = $clog2(MAX_KEPT);
   localparam int SW  = (IW < 1) ? 1 : IW;
   localparam int CW  = $clog2(MAX_KEPT + 1);
   localparam int DW  = EB + 1;

   cfg_type cfg;

   gbnm_cfg u_cfg (
      .clock(clock), .reset(reset), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data), .cfg(cfg)
   );

   // memories
   logic signed [CB-1:0] mem_l [MAX_KEPT];
   logic signed [CB-1:0] mem_t [MAX_KEPT];
   logic signed [EB-1:0] mem_r [MAX_KEPT];
   logic signed [EB-1:0] mem_b [MAX_KEPT];
   logic [23:0]          mem_a [MAX_KEPT];
   logic [15:0]          mem_s [MAX_KEPT];
   logic [5:0]           mem_c [MAX_KEPT];

   state_type state_ff, state_in;

   logic signed [CB-1:0] l_ff, t_ff;
   logic signed [EB-1:0] r_ff, b_ff;
   logic [23:0] area_ff;
   logic [15:0] sc_ff;
   logic [5:0]  cc_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] rd_j_ff;
   logic rd_vld_ff;
   logic sup_ff, sup_in;
   logic [31:0] mask_ff, mask_in;

   // read data registers
   logic signed [CB-1:0] kl_ff, kt_ff;
   logic signed [EB-1:0] kr_ff, kb_ff;
   logic [23:0] ka_ff;
   logic [15:0] ks_ff;
   logic [5:0]  kc_ff;

   // stage 2 registers
   logic        p_vld_ff;
   logic [CW-1:0] p_j_ff;
   logic [24:0] inter_ff;
   logic [25:0] uni_ff;
   logic        dok_ff, ccok_ff;

   logic [39:0] rsp_ff;
   logic        rsp_vld_ff;

   logic tbl_full;
   logic store_en;
   assign tbl_full = 32'(count_ff) >= 32'(MAX_KEPT);
   assign store_en = (state_ff == ST_WRITE) && !sup_ff && !tbl_full;

   logic signed [CB-1:0] in_l, in_t;
   logic [11:0] in_w, in_h;
   assign in_l = req_tdata[CB-1:0];
   assign in_t = req_tdata[2*CB-1:CB];
   assign in_w = req_tdata[2*CB+11:2*CB];
   assign in_h = req_tdata[2*CB+23:2*CB+12];

   logic req_acc;
   assign req_tready = (state_ff == ST_IDLE) && !rsp_vld_ff;
   assign req_acc = req_tvalid && req_tready;

   // shared unit, stage 1: intersection and union
   logic signed [EB-1:0] x1, y1, x2, y2;
   logic signed [DW-1:0] dx, dy;
   logic [24:0] inter_c;
   logic [15:0] dsc;
   always_comb begin
      x1 = (EB'(l_ff) > EB'(kl_ff)) ? EB'(l_ff) : EB'(kl_ff);
      y1 = (EB'(t_ff) > EB'(kt_ff)) ? EB'(t_ff) : EB'(kt_ff);
      x2 = (r_ff < kr_ff) ? r_ff : kr_ff;
      y2 = (b_ff < kb_ff) ? b_ff : kb_ff;
      dx = DW'(x2) - DW'(x1);
      dy = DW'(y2) - DW'(y1);
      if (dx > 0 && dy > 0) inter_c = 25'(dx[DW-2:0]) * 25'(dy[DW-2:0]);
      else inter_c = '0;
      dsc = (sc_ff > ks_ff) ? sc_ff - ks_ff : ks_ff - sc_ff;
   end

   // stage 2: threshold products
   logic [41:0] inter_sh, p_thr, p_mrg;
   logic above_thr, above_mrg;
   always_comb begin
      inter_sh  = {1'b0, inter_ff, 16'b0};
      p_thr     = 42'(cfg.iou_thr) * 42'(uni_ff);
      p_mrg     = 42'(cfg.merge_iou) * 42'(uni_ff);
      above_thr = inter_sh > p_thr;
      above_mrg = inter_sh > p_mrg;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_acc) state_in = ST_READ;
         ST_READ:  if (j_ff >= count_ff && !rd_vld_ff && !p_vld_ff) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      j_in = j_ff;
      sup_in = sup_ff;
      mask_in = mask_ff;
      if (state_ff == ST_IDLE && req_acc) begin
         if (req_tuser) count_in = '0;
         j_in = '0;
         sup_in = 1'b0;
         mask_in = '0;
      end
      if (state_ff == ST_READ && j_ff < count_ff) j_in = j_ff + 1'b1;
      if (p_vld_ff) begin
         if (uni_ff == '0) sup_in = 1'b1;
         else if (above_thr) begin
            sup_in = 1'b1;
            if (above_mrg && dok_ff && ccok_ff && (32'(p_j_ff) < 32'd32))
               mask_in = mask_ff | (32'd1 << p_j_ff[4:0]);
         end
      end
      if (store_en) count_in = count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rd_vld_ff <= 1'b0;
         p_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rd_vld_ff <= (state_ff == ST_READ) && (j_ff < count_ff);
         p_vld_ff <= rd_vld_ff;
         if (state_ff == ST_OUT) rsp_vld_ff <= 1'b1;
         else if (rsp_tready) rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      j_ff <= j_in;
      sup_ff <= sup_in;
      mask_ff <= mask_in;
      rd_j_ff <= j_ff;
      if (req_acc) begin
         l_ff <= in_l;
         t_ff <= in_t;
         r_ff <= EB'(in_l) + EB'($signed({1'b0, in_w}));
         b_ff <= EB'(in_t) + EB'($signed({1'b0, in_h}));
         area_ff <= 24'(in_w) * 24'(in_h);
         sc_ff <= req_tdata[2*CB+39:2*CB+24];
         cc_ff <= {req_tdata[2*CB+43:2*CB+40], req_tdata[2*CB+45:2*CB+44]};
      end
      kl_ff <= mem_l[j_ff[SW-1:0]];
      kt_ff <= mem_t[j_ff[SW-1:0]];
      kr_ff <= mem_r[j_ff[SW-1:0]];
      kb_ff <= mem_b[j_ff[SW-1:0]];
      ka_ff <= mem_a[j_ff[SW-1:0]];
      ks_ff <= mem_s[j_ff[SW-1:0]];
      kc_ff <= mem_c[j_ff[SW-1:0]];
      p_j_ff <= rd_j_ff;
      inter_ff <= inter_c;
      uni_ff <= 26'(area_ff) + 26'(ka_ff) - 26'(inter_c);
      dok_ff <= dsc < cfg.merge_tol;
      ccok_ff <= cc_ff == kc_ff;
      if (store_en) begin
         mem_l[count_ff[SW-1:0]] <= l_ff;
         mem_t[count_ff[SW-1:0]] <= t_ff;
         mem_r[count_ff[SW-1:0]] <= r_ff;
         mem_b[count_ff[SW-1:0]] <= b_ff;
         mem_a[count_ff[SW-1:0]] <= area_ff;
         mem_s[count_ff[SW-1:0]] <= sc_ff;
         mem_c[count_ff[SW-1:0]] <= cc_ff;
      end
      if (state_ff == ST_WRITE)
         rsp_ff <= {1'b0, !sup_ff && tbl_full, mask_ff,
                    store_en ? 5'(count_ff) : 5'd0, store_en};
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata = rsp_ff;
endmodule
